[src/assert_macros.svh]
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)

`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`define ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

[src/rfrc_pkg.sv]
package rfrc_pkg;

   localparam logic [7:0]  FUNC_MULTI_WRITE = 8'h10;
   localparam logic [8:0]  LEN_PLAIN        = 9'd8;
   localparam logic [8:0]  LEN_EXTRA        = 9'd9;
   localparam logic [15:0] CRC_POLY         = 16'hA001;
   localparam logic [15:0] CRC_INIT         = 16'hFFFF;
   localparam logic [7:0]  ADDR_RESET       = 8'd1;
   localparam logic [8:0]  POS_FUNC         = 9'd1;
   localparam logic [8:0]  POS_COUNT        = 9'd6;

   typedef struct packed {
      logic       byte_taken;
      logic [8:0] position;
      logic       frame_good;
      logic       crc_bad;
   } rfrc_result_type;

   // one byte folded into a reflected crc-16, unrolled over eight bit steps
   function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

[src/rfrc_frame_engine.sv]
module rfrc_frame_engine
   import rfrc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  logic [7:0]      rx_byte,
   input  logic [7:0]      slave_address,
   output rfrc_result_type result
);

   logic [8:0]  bytes_so_far_ff, bytes_so_far_in;
   logic [7:0]  function_code_ff, function_code_in;
   logic [7:0]  data_byte_count_ff, data_byte_count_in;
   logic [15:0] running_crc_ff, running_crc_in;
   logic [7:0]  crc_low_seen_ff, crc_low_seen_in;

   logic        frame_open;
   logic        drop;
   logic [7:0]  func_eff;
   logic [7:0]  count_eff;
   logic [15:0] crc_eff;
   logic [9:0]  frame_len;
   logic [9:0]  pos_plus2;
   logic        crc_ok;

   always_comb begin
      frame_open = (bytes_so_far_ff != 9'd0);
      drop       = !frame_open && (rx_byte != slave_address);
      func_eff   = frame_open ? function_code_ff : 8'h00;
      count_eff  = frame_open ? data_byte_count_ff : 8'h00;
      crc_eff    = frame_open ? running_crc_ff : CRC_INIT;
      if (bytes_so_far_ff == POS_FUNC) begin
         func_eff = rx_byte;
      end
      if (bytes_so_far_ff == POS_COUNT) begin
         count_eff = rx_byte;
      end
      if (func_eff == FUNC_MULTI_WRITE) begin
         frame_len = {2'b00, count_eff} + {1'b0, LEN_EXTRA};
      end else begin
         frame_len = {1'b0, LEN_PLAIN};
      end
      pos_plus2 = {1'b0, bytes_so_far_ff} + 10'd2;
      crc_ok    = (crc_low_seen_ff == crc_eff[7:0]) && (rx_byte == crc_eff[15:8]);

      bytes_so_far_in    = bytes_so_far_ff;
      function_code_in   = function_code_ff;
      data_byte_count_in = data_byte_count_ff;
      running_crc_in     = running_crc_ff;
      crc_low_seen_in    = crc_low_seen_ff;
      result             = '0;

      if (!drop) begin
         function_code_in   = func_eff;
         data_byte_count_in = count_eff;
         result.byte_taken  = 1'b1;
         result.position    = bytes_so_far_ff;
         if (pos_plus2 < frame_len) begin
            running_crc_in  = crc_fold(crc_eff, rx_byte);
            bytes_so_far_in = bytes_so_far_ff + 9'd1;
         end else if (pos_plus2 == frame_len) begin
            running_crc_in  = crc_eff;
            crc_low_seen_in = rx_byte;
            bytes_so_far_in = bytes_so_far_ff + 9'd1;
         end else begin
            result.frame_good = crc_ok;
            result.crc_bad    = !crc_ok;
            bytes_so_far_in   = 9'd0;
            running_crc_in    = CRC_INIT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_so_far_ff    <= 9'd0;
         function_code_ff   <= 8'h00;
         data_byte_count_ff <= 8'h00;
         running_crc_ff     <= CRC_INIT;
         crc_low_seen_ff    <= 8'h00;
      end else if (step) begin
         bytes_so_far_ff    <= bytes_so_far_in;
         function_code_ff   <= function_code_in;
         data_byte_count_ff <= data_byte_count_in;
         running_crc_ff     <= running_crc_in;
         crc_low_seen_ff    <= crc_low_seen_in;
      end
   end

endmodule

[src/rtu_frame_receiver_checker_core.sv]
// Receiver and CRC-16 checker for address-gated serial frames.
// Request channel: req_valid / req_stall carry one received byte (req_rx_byte).
// A byte is taken when req_valid is high and req_stall is low.
// Response channel: rsp_valid / rsp_stall carry one response per request:
// rsp_byte_taken, rsp_position, rsp_frame_good and rsp_crc_bad.
// A frame opens only on a byte equal to the slave address written on the
// csr port (csr_wr_en, csr_wr_data); write it only while the block is idle.
// The response is registered: it appears in the cycle after its request is taken.
// Throughput: one request per cycle while req_stall is low; the crc update of a whole byte is one
// unrolled step between the frame state registers.
// When the receiver stalls, the response register holds its value and
// req_stall rises only while that register is full and stalled, so a new
// request is taken in the same cycle a waiting response leaves.
// Reset (synchronous, active high) closes any open frame, restores the
// slave address to 1 and empties the response register.
module rtu_frame_receiver_checker_core
   import rfrc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_byte_taken,
   output logic [8:0] rsp_position,
   output logic       rsp_frame_good,
   output logic       rsp_crc_bad
);

`include "assert_macros.svh"

   logic [7:0]      slave_address_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   rfrc_result_type result_ff;
   rfrc_result_type result_in;
   logic            req_take;
   logic            rsp_frame_end;

   assign req_stall    = rsp_valid_ff && rsp_stall;
   assign req_take     = req_valid && !req_stall;
   assign rsp_valid_in = req_take || (rsp_valid_ff && rsp_stall);

   rfrc_frame_engine u_engine (
      .clock         (clock),
      .reset         (reset),
      .step          (req_take),
      .rx_byte       (req_rx_byte),
      .slave_address (slave_address_ff),
      .result        (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_address_ff <= ADDR_RESET;
      end else if (csr_wr_en) begin
         slave_address_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload, loaded only when a request is taken
   always_ff @(posedge clock) begin
      if (req_take) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_byte_taken = result_ff.byte_taken;
   assign rsp_position   = result_ff.position;
   assign rsp_frame_good = result_ff.frame_good;
   assign rsp_crc_bad    = result_ff.crc_bad;
   assign rsp_frame_end  = rsp_frame_good || rsp_crc_bad;

   `ASSERT_NEXT(a_take_gives_rsp, clock, reset, req_take, rsp_valid)
   `ASSERT_NEVER(a_good_and_bad, clock, reset, rsp_valid && rsp_frame_good && rsp_crc_bad)
   `ASSERT_IMPLY(a_end_is_taken, clock, reset, rsp_valid && rsp_frame_end, rsp_byte_taken)
   `ASSERT_IMPLY(a_drop_is_zero, clock, reset, rsp_valid && !rsp_byte_taken, rsp_position == 9'd0)

endmodule

[test/rtu_frame_receiver_checker_core_tb.sv]
module rtu_frame_receiver_checker_core_tb
   import rfrc_pkg::*;
;

   // byte-level model of the frame receiver plus the queue of responses it owes
   class frame_checker_sb;
      logic [7:0]      address;
      int              frame_bytes;
      logic [7:0]      func_code;
      logic [7:0]      data_count;
      logic [15:0]     crc_acc;
      logic [7:0]      crc_lo;
      rfrc_result_type expected_q[$];
      int              errors;
      int              requests;
      int              frames_good;
      int              frames_bad;
      int              dropped;

      function new();
         address     = ADDR_RESET;
         frame_bytes = 0;
         func_code   = '0;
         data_count  = '0;
         crc_acc     = CRC_INIT;
         crc_lo      = '0;
         errors      = 0;
         requests    = 0;
         frames_good = 0;
         frames_bad  = 0;
         dropped     = 0;
      endfunction

      static function logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
         logic [15:0] c;
         c = crc ^ {8'h00, b};
         repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
         return c;
      endfunction

      function void set_address(logic [7:0] a);
         address = a;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void note_request(logic [7:0] b);
         rfrc_result_type r;
         int              pos;
         int              frame_len;
         r = '0;
         requests++;
         if (frame_bytes == 0 && b != address) begin
            dropped++;
            expected_q.push_back(r);
            return;
         end
         if (frame_bytes == 0) begin
            func_code  = '0;
            data_count = '0;
            crc_acc    = CRC_INIT;
         end
         pos = frame_bytes;
         if (pos == POS_FUNC) func_code = b;
         if (pos == POS_COUNT) data_count = b;
         frame_len = (func_code == FUNC_MULTI_WRITE) ? int'(data_count) + int'(LEN_EXTRA)
                                                     : int'(LEN_PLAIN);
         r.byte_taken = 1'b1;
         r.position   = 9'(pos);
         if (pos + 2 < frame_len) begin
            crc_acc     = crc_byte(crc_acc, b);
            frame_bytes = pos + 1;
         end else if (pos + 2 == frame_len) begin
            crc_lo      = b;
            frame_bytes = pos + 1;
         end else begin
            if (crc_lo == crc_acc[7:0] && b == crc_acc[15:8]) begin
               r.frame_good = 1'b1;
               frames_good++;
            end else begin
               r.crc_bad = 1'b1;
               frames_bad++;
            end
            frame_bytes = 0;
            crc_acc     = CRC_INIT;
         end
         expected_q.push_back(r);
      endfunction

      function void compare_field(string field, logic [8:0] want, logic [8:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_response(rfrc_result_type got);
         rfrc_result_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected response, expected none, got %p", $time, got);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         compare_field("byte_taken", 9'(want.byte_taken), 9'(got.byte_taken));
         compare_field("position", want.position, got.position);
         compare_field("frame_good", 9'(want.frame_good), 9'(got.frame_good));
         compare_field("crc_bad", 9'(want.crc_bad), 9'(got.crc_bad));
      endfunction
   endclass

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       csr_wr_en   = 1'b0;
   logic [7:0] csr_wr_data = 8'h00;
   logic       req_valid   = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall   = 1'b0;
   logic       rsp_byte_taken;
   logic [8:0] rsp_position;
   logic       rsp_frame_good;
   logic       rsp_crc_bad;

   frame_checker_sb sb = new();
   int              responses_seen = 0;
   bit              no_gaps = 1'b0;
   bit              long_hold_done = 1'b0;

   rtu_frame_receiver_checker_core dut (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_byte_taken (rsp_byte_taken),
      .rsp_position   (rsp_position),
      .rsp_frame_good (rsp_frame_good),
      .rsp_crc_bad    (rsp_crc_bad)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // responses are checked before requests are noted: a response never comes in the cycle its request is taken
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            sb.check_response('{rsp_byte_taken, rsp_position, rsp_frame_good, rsp_crc_bad});
            responses_seen++;
         end
         if (req_valid && !req_stall) sb.note_request(req_rx_byte);
      end
   end

   function automatic int idle_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = no_gaps ? 0 : idle_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_address(input logic [7:0] a);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= a;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_address(a);
   endtask

   // builds a frame with its crc trailer, optionally damaged or cut short
   task automatic send_frame(input logic [7:0] addr, input logic [7:0] func,
                             input logic [7:0] count, input logic [15:0] crc_flip,
                             input int cut);
      logic [7:0]  frame_q[$];
      logic [15:0] crc;
      int          frame_len;
      frame_len = (func == FUNC_MULTI_WRITE) ? int'(count) + int'(LEN_EXTRA) : int'(LEN_PLAIN);
      frame_q.push_back(addr);
      frame_q.push_back(func);
      for (int i = 2; i < frame_len - 2; i++) begin
         frame_q.push_back((i == POS_COUNT) ? count : 8'($urandom));
      end
      crc = CRC_INIT;
      foreach (frame_q[i]) crc = frame_checker_sb::crc_byte(crc, frame_q[i]);
      crc ^= crc_flip;
      frame_q.push_back(crc[7:0]);
      frame_q.push_back(crc[15:8]);
      if (cut > 0 && cut < frame_q.size()) frame_q = frame_q[0:cut-1];
      foreach (frame_q[i]) send_byte(frame_q[i]);
   endtask

   task automatic run_random(input logic [7:0] addr, input int n_items);
      int          stop_at;
      int          r;
      logic [7:0]  func;
      logic [7:0]  count;
      logic [15:0] flip;
      int          cut;
      stop_at = sb.requests + n_items;
      while (sb.requests < stop_at) begin
         no_gaps = ($urandom_range(0, 3) == 0);
         r = $urandom_range(0, 99);
         if (r < 82) begin
            r = $urandom_range(0, 99);
            if (r < 45) func = FUNC_MULTI_WRITE;
            else if (r < 60) func = 8'h03;
            else func = 8'($urandom);
            if (func == FUNC_MULTI_WRITE)
               count = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 12))
                                                  : 8'($urandom_range(13, 40));
            else
               count = 8'($urandom);
            flip = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(1, 16'hFFFF)) : 16'h0000;
            cut  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 7) : 0;
            send_frame(addr, func, count, flip, cut);
         end else begin
            // line noise between frames
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
         end
         // wait for the trailing request to land before sampling the counter
         while (req_valid && req_stall) @(posedge clock);
      end
   endtask

   // receiver side: random stalls, one long hold-off to back the block up
   initial begin
      int stall_len;
      int free_len;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!long_hold_done && responses_seen >= 300) begin
            long_hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (60) @(posedge clock);
         end else begin
            stall_len = ($urandom_range(0, 1) == 0) ? 0 :
                        ($urandom_range(0, 9) < 9) ? $urandom_range(1, 3) : $urandom_range(10, 25);
            free_len  = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(20, 80);
            if (stall_len > 0) begin
               rsp_stall <= 1'b1;
               repeat (stall_len) @(posedge clock);
            end
            rsp_stall <= 1'b0;
            repeat (free_len) @(posedge clock);
         end
      end
   end

   initial begin
      int limit;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: dropped bytes, clean plain frame, then a multi-write and a plain frame with bad trailers
      no_gaps = 1'b1;
      send_byte(8'h00);
      send_byte(8'hFF);
      send_frame(ADDR_RESET, 8'h03, 8'h00, 16'h0000, 0);
      send_frame(ADDR_RESET, FUNC_MULTI_WRITE, 8'h00, 16'h8000, 0);
      send_frame(ADDR_RESET, 8'h06, 8'h00, 16'h0001, 0);
      wait_drained();

      write_address(8'h00);
      run_random(8'h00, 250);
      wait_drained();

      // longest frame, then random traffic at the top address
      write_address(8'hFF);
      no_gaps = 1'b0;
      send_frame(8'hFF, FUNC_MULTI_WRITE, 8'hFF, 16'h0000, 0);
      run_random(8'hFF, 150);

      // leave a frame open across an address change
      send_frame(8'hFF, FUNC_MULTI_WRITE, 8'h04, 16'h0000, 3);
      wait_drained();
      write_address(8'($urandom_range(2, 254)));
      run_random(sb.address, 230);

      req_valid <= 1'b0;
      limit = 0;
      while (sb.pending() != 0 && limit < 2000) begin
         @(posedge clock);
         limit++;
      end
      repeat (5) @(posedge clock);
      if (sb.pending() != 0) begin
         $display("%0t: %0d responses never arrived, expected 0 left, got %0d",
                  $time, sb.pending(), sb.pending());
         sb.errors++;
      end
      $display("run covered %0d bytes: %0d good frames, %0d crc errors, %0d bytes dropped",
               sb.requests, sb.frames_good, sb.frames_bad, sb.dropped);
      if (sb.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
